>>> src/mqtt_packet_header_parser_defines.svh
// Assertion macros for the MQTT packet header parser.
`ifndef MQTT_PACKET_HEADER_PARSER_DEFINES_SVH
`define MQTT_PACKET_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define MQTT_HDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define MQTT_HDR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MQTT_HDR_ASSERT(lbl, prop, msg)
`define MQTT_HDR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/mqtt_hdr_pkg.sv
// Shared types and codes of the MQTT packet header parser.
package mqtt_hdr_pkg;

  localparam int unsigned MAX_TOPIC_DEF = 256;

  localparam int unsigned LEN_W   = 28;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned ST_W    = 3;

  localparam logic [CLS_W-1:0] CLS_TYPE    = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LEN     = 3'd1;
  localparam logic [CLS_W-1:0] CLS_TLEN    = 3'd2;
  localparam logic [CLS_W-1:0] CLS_KEPT    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_DROPPED = 3'd4;
  localparam logic [CLS_W-1:0] CLS_ID      = 3'd5;
  localparam logic [CLS_W-1:0] CLS_PAYLOAD = 3'd6;
  localparam logic [CLS_W-1:0] CLS_OTHER   = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_TLEN  = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERRUN  = 3'd2;
  localparam logic [ST_W-1:0] ST_MISS_ID  = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNC    = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD_LEN  = 3'd5;

  localparam logic [3:0] T_PUBLISH = 4'd3;
  localparam logic [3:0] T_PUBACK  = 4'd4;
  localparam logic [3:0] T_PUBCOMP = 4'd7;
  localparam logic [3:0] T_SUBACK  = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [CLS_W-1:0] byte_class;
    logic [7:0]       byte_value;
    logic [3:0]       packet_type;
    logic [3:0]       packet_flags;
    logic [LEN_W-1:0] remaining_length;
    logic [15:0]      topic_len;
    logic [15:0]      msg_id;
    logic [ST_W-1:0]  status;
    logic             packet_end;
  } out_item_t;

endpackage

>>> src/mqtt_hdr_core.sv
// Parse state and per-byte decode of the MQTT packet header parser.
`include "mqtt_packet_header_parser_defines.svh"

module mqtt_hdr_core #(
  parameter int unsigned MAX_TOPIC = mqtt_hdr_pkg::MAX_TOPIC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  mqtt_hdr_pkg::in_item_t item,
  output mqtt_hdr_pkg::out_item_t res
);
  import mqtt_hdr_pkg::*;

  localparam logic [2:0] PH_TYPE    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_TLEN    = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_ID      = 3'd4;
  localparam logic [2:0] PH_PAY     = 3'd5;
  localparam logic [2:0] PH_OTHER   = 3'd6;
  localparam logic [2:0] PH_DISCARD = 3'd7;

  logic [2:0]       phase_r, phase_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [1:0]       lbc_r, lbc_nxt;
  logic [LEN_W-1:0] bl_r, bl_nxt;
  logic [15:0]      tl_r, tl_nxt;
  logic [15:0]      tc_r, tc_nxt;
  logic [15:0]      pid_r, pid_nxt;
  logic             idc_r, idc_nxt;
  logic [3:0]       type_r, type_nxt;
  logic [3:0]       flags_r, flags_nxt;

  logic [7:0]       b;
  logic             last;
  logic [LEN_W-1:0] bl_dec;
  logic [LEN_W-1:0] len_part;
  logic             id_type;
  logic [2:0]       at_phase;
  logic [ST_W-1:0]  at_st;
  logic [2:0]       nxt;
  logic [CLS_W-1:0] cls;
  logic [ST_W-1:0]  st;
  logic             pend;
  logic             hide_tlen;
  logic             hide_id;

  assign b       = item.data_byte;
  assign last    = item.buffer_end;
  assign bl_dec  = (bl_r != '0) ? bl_r - LEN_W'(1) : bl_r;
  assign id_type = (type_r == T_SUBACK) || (type_r >= T_PUBACK && type_r <= T_PUBCOMP);

  always_comb begin
    case (lbc_r)
      2'd0:    len_part = LEN_W'(b[6:0]);
      2'd1:    len_part = LEN_W'(b[6:0]) << 7;
      2'd2:    len_part = LEN_W'(b[6:0]) << 14;
      default: len_part = LEN_W'(b[6:0]) << 21;
    endcase
  end

  // after the topic: packet id when QoS is set (missing id if under two bytes remain), else payload if bytes remain
  always_comb begin
    at_st = ST_OK;
    if (flags_r[2:1] != 2'b00) begin
      if (bl_dec < LEN_W'(2)) begin
        at_st    = ST_MISS_ID;
        at_phase = (bl_dec == '0) ? PH_TYPE : PH_OTHER;
      end else begin
        at_phase = PH_ID;
      end
    end else begin
      at_phase = (bl_dec == '0) ? PH_TYPE : PH_PAY;
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    lbc_nxt   = lbc_r;
    bl_nxt    = bl_r;
    tl_nxt    = tl_r;
    tc_nxt    = tc_r;
    pid_nxt   = pid_r;
    idc_nxt   = idc_r;
    type_nxt  = type_r;
    flags_nxt = flags_r;
    cls       = CLS_OTHER;
    st        = ST_OK;
    nxt       = PH_TYPE;
    hide_tlen = 1'b0;
    hide_id   = 1'b0;
    unique case (phase_r) inside
      PH_TYPE: begin
        cls       = CLS_TYPE;
        type_nxt  = b[7:4];
        flags_nxt = b[3:0];
        acc_nxt   = '0;
        lbc_nxt   = '0;
        bl_nxt    = '0;
        tl_nxt    = '0;
        tc_nxt    = '0;
        pid_nxt   = '0;
        idc_nxt   = 1'b0;
        nxt       = PH_LEN;
      end
      PH_LEN: begin
        cls     = CLS_LEN;
        acc_nxt = acc_r | len_part;
        if (b[7]) begin
          if (lbc_r == 2'd3) begin
            st  = ST_BAD_LEN;
            nxt = PH_DISCARD;
          end else begin
            lbc_nxt = lbc_r + 2'd1;
            nxt     = PH_LEN;
          end
        end else begin
          bl_nxt = acc_nxt;
          if (type_r == T_PUBLISH || id_type) begin
            if (acc_nxt < LEN_W'(2)) begin
              st  = (type_r == T_PUBLISH) ? ST_NO_TLEN : ST_MISS_ID;
              nxt = (acc_nxt == '0) ? PH_TYPE : PH_OTHER;
            end else begin
              idc_nxt = 1'b0;
              nxt     = (type_r == T_PUBLISH) ? PH_TLEN : PH_ID;
            end
          end else begin
            nxt = (acc_nxt == '0) ? PH_TYPE : PH_OTHER;
          end
        end
      end
      PH_TLEN: begin
        cls    = CLS_TLEN;
        bl_nxt = bl_dec;
        if (!idc_r) begin
          tl_nxt    = {b, 8'h00};
          idc_nxt   = 1'b1;
          hide_tlen = 1'b1;
          nxt       = PH_TLEN;
        end else begin
          tl_nxt  = tl_r | {8'h00, b};
          idc_nxt = 1'b0;
          if (bl_dec < LEN_W'(tl_nxt)) begin
            st  = ST_OVERRUN;
            nxt = (bl_dec == '0) ? PH_TYPE : PH_OTHER;
          end else if (tl_nxt != '0) begin
            tc_nxt = '0;
            nxt    = PH_TOPIC;
          end else begin
            st  = at_st;
            nxt = at_phase;
          end
        end
      end
      PH_TOPIC: begin
        cls    = ({1'b0, tc_r} < 17'(MAX_TOPIC)) ? CLS_KEPT : CLS_DROPPED;
        bl_nxt = bl_dec;
        tc_nxt = tc_r + 16'd1;
        if (tc_nxt == tl_r) begin
          idc_nxt = 1'b0;
          st      = at_st;
          nxt     = at_phase;
        end else begin
          nxt = PH_TOPIC;
        end
      end
      PH_ID: begin
        cls    = CLS_ID;
        bl_nxt = bl_dec;
        if (!idc_r) begin
          pid_nxt = {b, 8'h00};
          idc_nxt = 1'b1;
          hide_id = 1'b1;
          nxt     = PH_ID;
        end else begin
          pid_nxt = pid_r | {8'h00, b};
          idc_nxt = 1'b0;
          if (bl_dec == '0) begin
            nxt = PH_TYPE;
          end else begin
            nxt = (type_r == T_PUBLISH) ? PH_PAY : PH_OTHER;
          end
        end
      end
      PH_PAY, PH_OTHER: begin
        cls    = (phase_r == PH_PAY) ? CLS_PAYLOAD : CLS_OTHER;
        bl_nxt = bl_dec;
        nxt    = (bl_dec == '0) ? PH_TYPE : phase_r;
      end
      default: begin
        cls = CLS_OTHER;
        nxt = last ? PH_TYPE : PH_DISCARD;
      end
    endcase

    // end the packet when the next phase is the type byte, and at the buffer end
    pend = (nxt == PH_TYPE);
    if (last && nxt != PH_TYPE) begin
      if (st == ST_OK) begin
        st = ST_TRUNC;
      end
      nxt  = PH_TYPE;
      pend = 1'b1;
    end
    phase_nxt = nxt;
  end

  always_comb begin
    res.byte_class       = cls;
    res.byte_value       = b;
    res.packet_type      = type_nxt;
    res.packet_flags     = flags_nxt;
    res.remaining_length = acc_nxt;
    res.topic_len        = hide_tlen ? 16'h0000 : tl_nxt;
    res.msg_id           = hide_id ? 16'h0000 : pid_nxt;
    res.status           = st;
    res.packet_end       = pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      acc_r   <= '0;
      lbc_r   <= '0;
      bl_r    <= '0;
      tl_r    <= '0;
      tc_r    <= '0;
      pid_r   <= '0;
      idc_r   <= 1'b0;
      type_r  <= '0;
      flags_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      lbc_r   <= lbc_nxt;
      bl_r    <= bl_nxt;
      tl_r    <= tl_nxt;
      tc_r    <= tc_nxt;
      pid_r   <= pid_nxt;
      idc_r   <= idc_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
    end
  end

  `MQTT_HDR_ASSERT(a_end_to_type, step_en && res.packet_end |=> phase_r == PH_TYPE, "end lost")
  `MQTT_HDR_ASSERT(a_mid_packet, step_en && !res.packet_end |=> phase_r != PH_TYPE, "early end")
  `MQTT_HDR_ASSERT(a_topic_cnt, phase_r == PH_TOPIC |-> tc_r < tl_r, "topic count past length")
  `MQTT_HDR_ASSERT_NEVER(a_id_no_bytes, phase_r == PH_ID && bl_r == '0, "id with no bytes left")

endmodule

>>> src/mqtt_packet_header_parser.sv
// Top level of the MQTT packet header parser: input register, decode core, result register.
//
// Takes one stream byte per transfer and returns one classified result per byte.
// A byte passes through an input register and is then decoded into the result register;
// a byte is accepted every cycle while the result side does not stall, and its result
// is offered from the result register. The decode is a single pass of the per-byte
// parse state update in the core; a stall on the result side holds the result register
// and, once the input register is full, stalls input.
module mqtt_packet_header_parser #(
  parameter int unsigned MAX_TOPIC = mqtt_hdr_pkg::MAX_TOPIC_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  mqtt_hdr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mqtt_hdr_pkg::out_item_t out_data
);
  import mqtt_hdr_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t step_res;
  logic      out_ready;
  logic      step_en;
  logic      in_fire;

  assign out_ready     = !out_valid_r || !out_stall;
  assign step_en       = s1_valid_r && out_ready;
  assign in_stall      = s1_valid_r && !out_ready;
  assign in_fire       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !step_en);
  assign out_valid_nxt = step_en || (out_valid_r && out_stall);

  mqtt_hdr_core #(
    .MAX_TOPIC (MAX_TOPIC)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_data_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (step_en) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/mqtt_packet_header_parser_tb.sv
// Self-checking testbench for the MQTT packet header parser.
`timescale 1ns / 1ps

module mqtt_packet_header_parser_tb;
  import mqtt_hdr_pkg::*;

  localparam int unsigned LIMIT         = 200000;
  localparam int unsigned STREAM_BYTES  = 1580;
  localparam int unsigned TX_QUIET_FROM = 1200;
  localparam int unsigned TX_QUIET_TO   = 2200;
  localparam int unsigned RX_QUIET_FROM = 400;
  localparam int unsigned RX_QUIET_TO   = 1200;
  localparam int unsigned HOLD_FROM     = 1400;
  localparam int unsigned HOLD_LEN      = 300;

  typedef enum logic [2:0] {
    P_TYPE, P_LEN, P_TLEN, P_TOPIC, P_ID, P_PAYLOAD, P_BODY, P_SKIP
  } parse_phase_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t    stream_bytes[$];
  out_item_t   parsed_bytes[$];
  out_item_t   want;
  int unsigned fails = 0;
  int unsigned cyc = 0;
  int unsigned rx_cycles = 0;

  parse_phase_e    st_phase = P_TYPE;
  logic [LEN_W-1:0] len_sum = '0;
  logic [1:0]       len_idx = '0;
  logic [LEN_W-1:0] body_left = '0;
  logic [15:0]      topic_len_q = '0;
  logic [15:0]      topic_seen = '0;
  logic [15:0]      pid_q = '0;
  logic             half_seen = 1'b0;
  logic [3:0]       cur_type = '0;
  logic [3:0]       cur_flags = '0;

  mqtt_packet_header_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic parse_phase_e rest_as_body();
    return (body_left == 0) ? P_TYPE : P_BODY;
  endfunction

  function automatic parse_phase_e after_topic_phase(inout logic [ST_W-1:0] st);
    if ((cur_flags & 4'h6) != 4'h0) begin
      if (body_left < 2) begin
        st = ST_MISS_ID;
        return rest_as_body();
      end
      half_seen = 1'b0;
      return P_ID;
    end
    return (body_left == 0) ? P_TYPE : P_PAYLOAD;
  endfunction

  function automatic out_item_t parse_byte(in_item_t it);
    out_item_t        r;
    parse_phase_e     nxt;
    logic [ST_W-1:0]  st;
    logic [CLS_W-1:0] cls;
    logic             hide_tlen;
    logic             hide_id;
    logic             done;
    logic [7:0]       b;
    b = it.data_byte;
    st = ST_OK;
    cls = CLS_OTHER;
    nxt = P_TYPE;
    hide_tlen = 1'b0;
    hide_id = 1'b0;
    case (st_phase)
      P_TYPE: begin
        cls = CLS_TYPE;
        cur_type = b[7:4];
        cur_flags = b[3:0];
        len_sum = '0;
        len_idx = '0;
        body_left = '0;
        topic_len_q = '0;
        topic_seen = '0;
        pid_q = '0;
        half_seen = 1'b0;
        nxt = P_LEN;
      end
      P_LEN: begin
        cls = CLS_LEN;
        len_sum = len_sum | (LEN_W'(b[6:0]) << (7 * len_idx));
        if (b[7]) begin
          if (len_idx == 2'd3) begin
            st = ST_BAD_LEN;
            nxt = P_SKIP;
          end else begin
            len_idx = len_idx + 2'd1;
            nxt = P_LEN;
          end
        end else begin
          body_left = len_sum;
          if (cur_type == T_PUBLISH) begin
            if (body_left < 2) begin
              st = ST_NO_TLEN;
              nxt = rest_as_body();
            end else begin
              half_seen = 1'b0;
              nxt = P_TLEN;
            end
          end else if (cur_type == T_SUBACK ||
                       (cur_type >= T_PUBACK && cur_type <= T_PUBCOMP)) begin
            if (body_left < 2) begin
              st = ST_MISS_ID;
              nxt = rest_as_body();
            end else begin
              half_seen = 1'b0;
              nxt = P_ID;
            end
          end else begin
            nxt = rest_as_body();
          end
        end
      end
      P_TLEN: begin
        cls = CLS_TLEN;
        if (body_left != 0) body_left = body_left - LEN_W'(1);
        if (!half_seen) begin
          topic_len_q = {b, 8'h00};
          half_seen = 1'b1;
          hide_tlen = 1'b1;
          nxt = P_TLEN;
        end else begin
          topic_len_q[7:0] = b;
          half_seen = 1'b0;
          if (body_left < topic_len_q) begin
            st = ST_OVERRUN;
            nxt = rest_as_body();
          end else if (topic_len_q != 0) begin
            topic_seen = '0;
            nxt = P_TOPIC;
          end else begin
            nxt = after_topic_phase(st);
          end
        end
      end
      P_TOPIC: begin
        cls = (topic_seen < MAX_TOPIC_DEF) ? CLS_KEPT : CLS_DROPPED;
        if (body_left != 0) body_left = body_left - LEN_W'(1);
        topic_seen = topic_seen + 16'd1;
        if (topic_seen == topic_len_q) nxt = after_topic_phase(st);
        else nxt = P_TOPIC;
      end
      P_ID: begin
        cls = CLS_ID;
        if (body_left != 0) body_left = body_left - LEN_W'(1);
        if (!half_seen) begin
          pid_q = {b, 8'h00};
          half_seen = 1'b1;
          hide_id = 1'b1;
          nxt = P_ID;
        end else begin
          pid_q[7:0] = b;
          half_seen = 1'b0;
          if (body_left == 0) nxt = P_TYPE;
          else nxt = (cur_type == T_PUBLISH) ? P_PAYLOAD : P_BODY;
        end
      end
      P_PAYLOAD, P_BODY: begin
        cls = (st_phase == P_PAYLOAD) ? CLS_PAYLOAD : CLS_OTHER;
        if (body_left != 0) body_left = body_left - LEN_W'(1);
        nxt = (body_left == 0) ? P_TYPE : st_phase;
      end
      default: begin
        cls = CLS_OTHER;
        nxt = it.buffer_end ? P_TYPE : P_SKIP;
      end
    endcase
    done = (nxt == P_TYPE);
    if (it.buffer_end && nxt != P_TYPE) begin
      if (st == ST_OK) st = ST_TRUNC;
      nxt = P_TYPE;
      done = 1'b1;
    end
    st_phase = nxt;
    r.byte_class = cls;
    r.byte_value = b;
    r.packet_type = cur_type;
    r.packet_flags = cur_flags;
    r.remaining_length = len_sum;
    r.topic_len = hide_tlen ? 16'h0 : topic_len_q;
    r.msg_id = hide_id ? 16'h0 : pid_q;
    r.status = st;
    r.packet_end = done;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_item_t t;
    t.data_byte = b;
    t.buffer_end = last;
    stream_bytes.push_back(t);
  endtask

  task automatic add_random(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom_range(255)));
  endtask

  // Frame a packet: head byte, variable-length remaining length, body.
  task automatic push_packet(input logic [7:0] head, input logic [7:0] body[$],
                             input int end_at);
    logic [7:0]  pkt[$];
    int unsigned n;
    logic [7:0]  d;
    pkt.push_back(head);
    n = body.size();
    do begin
      d = {1'b0, n[6:0]};
      n = n >> 7;
      if (n != 0) d[7] = 1'b1;
      pkt.push_back(d);
    end while (n != 0);
    foreach (body[i]) pkt.push_back(body[i]);
    foreach (pkt[i])
      push_byte(pkt[i], (i == end_at) || (end_at >= pkt.size() && i == pkt.size() - 1));
  endtask

  task automatic check_field(input string name, input logic [27:0] exp_v,
                             input logic [27:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("[mqtt_packet_header_parser] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) parsed_bytes.push_back(parse_byte(in_data));
      if (stream_bytes.size() != 0 &&
          !((cyc < TX_QUIET_FROM || cyc >= TX_QUIET_TO) && $urandom_range(99) < 25)) begin
        in_data <= stream_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cycles <= 0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (out_valid && !out_stall) begin
        if (parsed_bytes.size() == 0) begin
          $error("result with none pending: byte_value %0d", out_data.byte_value);
          fails++;
        end else begin
          want = parsed_bytes.pop_front();
          check_field("byte_class", 28'(want.byte_class), 28'(out_data.byte_class));
          check_field("byte_value", 28'(want.byte_value), 28'(out_data.byte_value));
          check_field("packet_type", 28'(want.packet_type), 28'(out_data.packet_type));
          check_field("packet_flags", 28'(want.packet_flags), 28'(out_data.packet_flags));
          check_field("remaining_length", want.remaining_length,
                      out_data.remaining_length);
          check_field("topic_len", 28'(want.topic_len), 28'(out_data.topic_len));
          check_field("msg_id", 28'(want.msg_id), 28'(out_data.msg_id));
          check_field("status", 28'(want.status), 28'(out_data.status));
          check_field("packet_end", 28'(want.packet_end), 28'(out_data.packet_end));
        end
      end
      if (rx_cycles >= HOLD_FROM && rx_cycles < HOLD_FROM + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (rx_cycles >= RX_QUIET_FROM && rx_cycles < RX_QUIET_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  initial begin
    logic [8:0]  intro[] = '{
      9'h030, 9'h000,
      9'h070, 9'h000,
      9'h092, 9'h002, 9'h012, 9'h034,
      9'h03f, 9'h004, 9'h000, 9'h000, 9'h0ff, 9'h0ff,
      9'h030, 9'h002, 9'h0ff, 9'h0ff,
      9'h032, 9'h002, 9'h000, 9'h000,
      9'h000, 9'h0ff, 9'h0ff, 9'h0ff, 9'h17f,
      9'h0f0, 9'h080, 9'h080, 9'h080, 9'h180
    };
    logic [7:0]  body[$];
    logic [3:0]  t;
    logic [3:0]  fl;
    logic [15:0] tl;
    int          pick;
    int          cut;
    int          r;
    int          n;
    int          pkt_no;
    logic        big;
    foreach (intro[i]) push_byte(intro[i][7:0], intro[i][8]);
    pkt_no = 0;
    while (stream_bytes.size() < STREAM_BYTES) begin
      body.delete();
      fl = 4'($urandom_range(15));
      pick = $urandom_range(99);
      big = (pkt_no == 12 || pkt_no == 60);
      t = T_PUBLISH;
      if (big || pick < 50) begin
        tl = big ? 16'($urandom_range(256, 272)) : 16'($urandom_range(0, 12));
        body.push_back(tl[15:8]);
        body.push_back(tl[7:0]);
        add_random(body, int'(tl));
        if (fl[2:1] != 2'b00) add_random(body, 2);
        add_random(body, $urandom_range(0, 10));
      end else if (pick < 70) begin
        t = 4'(T_PUBACK + $urandom_range(0, 4));
        if (t > T_PUBCOMP) t = T_SUBACK;
        add_random(body, $urandom_range(2, 5));
      end else if (pick < 82) begin
        do t = 4'($urandom_range(15));
        while (t == T_PUBLISH || t == T_SUBACK || (t >= T_PUBACK && t <= T_PUBCOMP));
        add_random(body, $urandom_range(0, 6));
      end else if (pick < 90) begin
        case ($urandom_range(3))
          0: add_random(body, $urandom_range(0, 1));
          1: begin
            t = 4'(T_PUBACK + $urandom_range(0, 4));
            if (t > T_PUBCOMP) t = T_SUBACK;
            add_random(body, $urandom_range(0, 1));
          end
          2: begin
            tl = 16'($urandom_range(1, 65535));
            body.push_back(tl[15:8]);
            body.push_back(tl[7:0]);
            add_random(body, $urandom_range(0, (tl > 6) ? 5 : tl - 1));
          end
          default: begin
            fl[2:1] = 2'($urandom_range(1, 3));
            tl = 16'($urandom_range(0, 5));
            body.push_back(tl[15:8]);
            body.push_back(tl[7:0]);
            add_random(body, int'(tl));
            add_random(body, $urandom_range(0, 1));
          end
        endcase
      end else if (pick < 95) begin
        push_byte(8'($urandom_range(255)), 1'b0);
        repeat (3) push_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
        if ($urandom_range(1)) begin
          push_byte(8'($urandom_range(127)), 1'b1);
        end else begin
          n = $urandom_range(0, 4);
          push_byte(8'h80 | 8'($urandom_range(127)), n == 0);
          for (int i = 1; i <= n; i++) push_byte(8'($urandom_range(255)), i == n);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 1; i <= n; i++) push_byte(8'($urandom_range(255)), i == n);
      end
      if (big || pick < 90) begin
        r = $urandom_range(19);
        if (r < 2) cut = $urandom_range(0, body.size() + 1);
        else if (r == 2) cut = 1 << 30;
        else cut = -1;
        push_packet({t, fl}, body, cut);
      end
      pkt_no++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (stream_bytes.size() != 0 || in_valid) @(posedge clk);
    while (parsed_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) $display("[mqtt_packet_header_parser] OK");
    else $display("[mqtt_packet_header_parser] ERROR");
    $finish;
  end

endmodule
